### src/alr_pkg.sv
// Shared constants and field layout for the anti-aliased line rasteriser.
package alr_pkg;

   localparam int COORD_W    = 6;
   localparam int SIDE_W     = 7;
   localparam int LEVEL_W    = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   // Request tdata layout.
   localparam int REQ_X_LO = 0;
   localparam int REQ_Y_LO = REQ_X_LO + COORD_W;

   // Response tdata layout.
   localparam int RSP_MAIN_X_LO     = 0;
   localparam int RSP_MAIN_Y_LO     = RSP_MAIN_X_LO + COORD_W;
   localparam int RSP_MAIN_LEVEL_LO = RSP_MAIN_Y_LO + COORD_W;
   localparam int RSP_SIDE_X_LO     = RSP_MAIN_LEVEL_LO + LEVEL_W;
   localparam int RSP_SIDE_Y_LO     = RSP_SIDE_X_LO + SIDE_W;
   localparam int RSP_SIDE_LEVEL_LO = RSP_SIDE_Y_LO + SIDE_W;
   localparam int RSP_USED_W        = RSP_SIDE_LEVEL_LO + LEVEL_W;

   // Command codes carried in req_tuser.
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_LINE = 1'b1;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [SIDE_W-1:0]  side_type;

endpackage

### src/antialiased_line_rasterizer_top.sv
// Top level of the anti-aliased line rasteriser: command sequencer and stepper.
//
// Commands arrive on the req_ stream: req_tuser selects a pen move or a line,
// req_tdata carries the target point. A move produces no result. A line
// draws from the pen to the point and leaves the pen there; it
// produces one rsp_ transaction per pixel step along the major axis, with
// rsp_tlast on the final one. A zero-length line produces a single transaction
// with rsp_tuser set and all pixel fields zero.
// A line spends a setup state, in which the bit-serial slope divider is
// started, then waits in the divide state while the divider develops
// FRAC_BITS+6 quotient bits and hands the result over, then makes one step
// per cycle for |major| steps (up to 63) while the receiver keeps up.
// req_tready is high only while the sequencer is idle; the next command may be
// accepted while the last result still sits in the output register.
// While a result waits on the port with rsp_tready low, the stepper holds
// its position and the result stays unchanged. Reset clears the pen to the
// origin, empties the output register and returns the sequencer to idle.
module antialiased_line_rasterizer_top #(
   parameter int TILE_SIZE  = 64,
   parameter int LEVEL_BITS = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_x [5:0], point_y [11:6], zero [15:12]
   input  logic [alr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation [0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // main_x [5:0], main_y [11:6], main_level [19:12], side_x [26:20],
   // side_y [33:27], side_level [41:34], zero [47:42]
   output logic [alr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // empty_res [0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import alr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_STEP  = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   localparam coord_type TILE_MAX = COORD_W'(TILE_SIZE - 1);
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [2:0]          state_ff, state_in;
   coord_type           pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   coord_type           sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   coord_type           maj_ff, maj_in, mnr_ff, mnr_in;
   coord_type           dmaj_ff, dmaj_in, cnt_ff, cnt_in;
   logic                steep_ff, steep_in, neg_ff, neg_in;
   logic [FRAC_BITS:0]  e_ff, e_in, slope_ff, slope_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_empty_ff, rsp_empty_in, rsp_last_ff, rsp_last_in;

   coord_type           tx, ty, raw_x, raw_y;
   logic signed [COORD_W:0] dx, dy;
   coord_type           adx, ady, st_x, st_y;
   logic                steep_c, swap_c, neg_c;
   logic                div_start, div_done;
   logic [FRAC_BITS:0]  div_q;
   logic                out_free;
   logic [FRAC_BITS:0]  e_sum, side_frac;
   logic                wrap;
   coord_type           px, py;
   side_type            side_x, side_y;
   level_type           main_level, side_level;

   // The divider is started from the setup cycle, so it takes the orientation
   // straight from the latched endpoints.
   alr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (steep_c ? adx : ady),
      .denom    (steep_c ? ady : adx),
      .done     (div_done),
      .quotient (div_q)
   );

   alr_level #(.LEVEL_BITS(LEVEL_BITS), .FRAC_BITS(FRAC_BITS)) u_main_level (
      .frac  (e_sum),
      .level (main_level)
   );

   alr_level #(.LEVEL_BITS(LEVEL_BITS), .FRAC_BITS(FRAC_BITS)) u_side_level (
      .frac  (side_frac),
      .level (side_level)
   );

   always_comb begin
      raw_x = req_tdata[REQ_X_LO +: COORD_W];
      raw_y = req_tdata[REQ_Y_LO +: COORD_W];
      tx    = (raw_x > TILE_MAX) ? TILE_MAX : raw_x;
      ty    = (raw_y > TILE_MAX) ? TILE_MAX : raw_y;

      // Line geometry from the latched endpoints.
      dx      = $signed({1'b0, ex_ff}) - $signed({1'b0, sx_ff});
      dy      = $signed({1'b0, ey_ff}) - $signed({1'b0, sy_ff});
      adx     = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady     = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      steep_c = ady > adx;
      swap_c  = steep_c ? dy[COORD_W] : dx[COORD_W];
      neg_c   = (steep_c ? dx[COORD_W] : dy[COORD_W]) ^ swap_c;
      st_x    = swap_c ? ex_ff : sx_ff;
      st_y    = swap_c ? ey_ff : sy_ff;

      // One pixel step.
      e_sum     = e_ff + slope_ff;
      wrap      = e_sum[FRAC_BITS];
      side_frac = wrap ? '0 : ONE - e_sum;
      px        = steep_ff ? mnr_ff : maj_ff;
      py        = steep_ff ? maj_ff : mnr_ff;
      side_x    = steep_ff ? {1'b0, px} + 1'b1 : {1'b0, px};
      side_y    = steep_ff ? {1'b0, py} : {1'b0, py} + 1'b1;
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      maj_in       = maj_ff;
      mnr_in       = mnr_ff;
      dmaj_in      = dmaj_ff;
      cnt_in       = cnt_ff;
      steep_in     = steep_ff;
      neg_in       = neg_ff;
      e_in         = e_ff;
      slope_in     = slope_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pen_x_in = tx;
               pen_y_in = ty;
               if (req_tuser == OP_LINE) begin
                  sx_in    = pen_x_ff;
                  sy_in    = pen_y_ff;
                  ex_in    = tx;
                  ey_in    = ty;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            if (adx == '0 && ady == '0) begin
               state_in = ST_EMPTY;
            end else begin
               steep_in  = steep_c;
               neg_in    = neg_c;
               maj_in    = steep_c ? st_y : st_x;
               mnr_in    = steep_c ? st_x : st_y;
               dmaj_in   = steep_c ? ady : adx;
               cnt_in    = '0;
               e_in      = '0;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               slope_in = div_q;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = 1'b0;
               rsp_last_in  = (cnt_ff == dmaj_ff - 1'b1);
               rsp_data_in  = '0;
               rsp_data_in[RSP_MAIN_X_LO +: COORD_W]     = px;
               rsp_data_in[RSP_MAIN_Y_LO +: COORD_W]     = py;
               rsp_data_in[RSP_MAIN_LEVEL_LO +: LEVEL_W] = main_level;
               rsp_data_in[RSP_SIDE_X_LO +: SIDE_W]      = side_x;
               rsp_data_in[RSP_SIDE_Y_LO +: SIDE_W]      = side_y;
               rsp_data_in[RSP_SIDE_LEVEL_LO +: LEVEL_W] = side_level;
               e_in   = {1'b0, e_sum[FRAC_BITS-1:0]};
               maj_in = maj_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (wrap) begin
                  mnr_in = neg_ff ? mnr_ff - 1'b1 : mnr_ff + 1'b1;
               end
               if (cnt_ff == dmaj_ff - 1'b1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      maj_ff       <= maj_in;
      mnr_ff       <= mnr_in;
      dmaj_ff      <= dmaj_in;
      cnt_ff       <= cnt_in;
      steep_ff     <= steep_in;
      neg_ff       <= neg_in;
      e_ff         <= e_in;
      slope_ff     <= slope_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff)
      else $error("empty line result without last marker");

   a_error_below_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> e_ff < ONE)
      else $error("error term not reduced below one");

   a_step_count_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> cnt_ff < dmaj_ff)
      else $error("step counter ran past the line length");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("slope ready outside the divide phase");

endmodule

### src/alr_div.sv
// Iterative restoring divider producing the Q1.FRAC_BITS slope, one bit per cycle.
module alr_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  alr_pkg::coord_type      numer,
   input  alr_pkg::coord_type      denom,
   output logic                    done,
   output logic [FRAC_BITS:0]      quotient
);
   import alr_pkg::*;

   localparam int ACC_W = FRAC_BITS + COORD_W;
   localparam int CNT_W = $clog2(ACC_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [COORD_W:0]   rem_ff, rem_in;
   coord_type          div_ff, div_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COORD_W:0]   trial;
   logic               fits;

   always_comb begin
      trial   = {rem_ff[COORD_W-1:0], acc_ff[ACC_W-1]};
      fits    = trial >= {1'b0, div_ff};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {numer, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         div_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, div_ff} : trial;
         acc_in = {acc_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff[FRAC_BITS:0];

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < {1'b0, div_ff})
      else $error("divider remainder not below divisor");

   a_done_single_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider still busy when done");

endmodule

### src/alr_level.sv
// Converts an error fraction to a saturated grey level by shift and subtract.
module alr_level #(
   parameter int LEVEL_BITS = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic [FRAC_BITS:0]  frac,
   output alr_pkg::level_type  level
);
   import alr_pkg::*;

   localparam int PROD_W = FRAC_BITS + 1 + LEVEL_BITS;
   localparam logic [LEVEL_BITS:0] LMAX = {1'b0, {LEVEL_BITS{1'b1}}};

   logic [PROD_W-1:0]          prod;
   logic [LEVEL_BITS:0]        scaled;
   logic [LEVEL_BITS-1:0]      sat;
   logic [LEVEL_BITS+LEVEL_W-1:0] wide;

   always_comb begin
      // frac * (2^LEVEL_BITS - 1) without a multiplier.
      prod   = {frac, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, frac};
      scaled = prod[PROD_W-1:FRAC_BITS];
      sat    = (scaled > LMAX) ? LMAX[LEVEL_BITS-1:0] : scaled[LEVEL_BITS-1:0];
      wide   = {{LEVEL_W{1'b0}}, sat};
      level  = wide[LEVEL_W-1:0];
   end

endmodule

### bench/antialiased_line_rasterizer_top_test.sv
// Self-checking testbench for the anti-aliased line rasteriser: pen moves, lines, pixel checks.
module antialiased_line_rasterizer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import alr_pkg::*;

   localparam int              FRAC_BITS  = 16;
   localparam longint unsigned UNIT_ERR   = 64'd1 << FRAC_BITS;
   localparam longint unsigned LEVEL_MAX  = 64'd255;
   localparam int              IDLE_LIMIT = 4000;
   localparam int              HOLD_OFF   = 400;

   typedef struct packed {
      logic      op;
      coord_type x;
      coord_type y;
   } command_type;

   typedef struct packed {
      coord_type main_x;
      coord_type main_y;
      level_type main_level;
      side_type  side_x;
      side_type  side_y;
      level_type side_level;
      logic      is_empty;
      logic      is_last;
   } raster_pixel_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = OP_MOVE;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;

   command_type      pending_cmds[$];
   raster_pixel_type expected_pixels[$];

   // Pen as the predictor sees it, and as the stimulus generator tracks it.
   coord_type pen_x = '0, pen_y = '0;
   coord_type gen_x = '0, gen_y = '0;

   int mismatches     = 0;
   int moves_seen     = 0;
   int steep_lines    = 0;
   int shallow_lines  = 0;
   int zero_lines     = 0;
   int pixels_checked = 0;
   int input_stalls   = 0;

   antialiased_line_rasterizer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic level_type gray_of(longint unsigned err);
      longint unsigned l;
      l = (err * LEVEL_MAX) >> FRAC_BITS;
      return (l > LEVEL_MAX) ? level_type'(LEVEL_MAX) : level_type'(l);
   endfunction

   // Works out the pixels one command produces and queues them in order.
   function automatic void rasterise(logic op, coord_type tx, coord_type ty);
      int               sx, sy, ex, ey, dx, dy, dmaj, dmin, step_dir, maj, mnr, px, py, t;
      bit               steep;
      longint unsigned  slope, err;
      raster_pixel_type pix;
      if (op == OP_MOVE) begin
         pen_x = tx;
         pen_y = ty;
         moves_seen++;
         return;
      end
      sx = pen_x; sy = pen_y; ex = tx; ey = ty;
      pen_x = tx;
      pen_y = ty;
      if (sx == ex && sy == ey) begin
         pix = '0;
         pix.is_empty = 1'b1;
         pix.is_last  = 1'b1;
         expected_pixels.push_back(pix);
         zero_lines++;
         return;
      end
      dx = ex - sx;
      dy = ey - sy;
      steep = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
      if (steep) steep_lines++;
      else shallow_lines++;
      // Always walk from the end with the lower major coordinate.
      if ((steep && dy < 0) || (!steep && dx < 0)) begin
         t = sx; sx = ex; ex = t;
         t = sy; sy = ey; ey = t;
         dx = -dx;
         dy = -dy;
      end
      dmaj = steep ? dy : dx;
      dmin = steep ? dx : dy;
      step_dir = (dmin < 0) ? -1 : 1;
      if (dmin < 0) dmin = -dmin;
      slope = (longint'(dmin) << FRAC_BITS) / dmaj;
      maj = steep ? sy : sx;
      mnr = steep ? sx : sy;
      err = 0;
      for (int i = 0; i < dmaj; i++) begin
         px = steep ? mnr : maj;
         py = steep ? maj : mnr;
         err += slope;
         pix.main_x     = coord_type'(px);
         pix.main_y     = coord_type'(py);
         pix.main_level = gray_of(err);
         pix.side_x     = side_type'(steep ? px + 1 : px);
         pix.side_y     = side_type'(steep ? py : py + 1);
         pix.side_level = (err >= UNIT_ERR) ? '0 : gray_of(UNIT_ERR - err);
         pix.is_empty   = 1'b0;
         pix.is_last    = (i + 1 == dmaj);
         expected_pixels.push_back(pix);
         if (err >= UNIT_ERR) begin
            err -= UNIT_ERR;
            mnr = (mnr + step_dir) & 63;
         end
         maj = (maj + 1) & 63;
      end
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic add_cmd(logic op, coord_type x, coord_type y);
      command_type c;
      c.op = op;
      c.x  = x;
      c.y  = y;
      pending_cmds.push_back(c);
      gen_x = x;
      gen_y = y;
   endtask

   function automatic coord_type near_coord(coord_type c);
      int v;
      v = int'(c) + $urandom_range(0, 16) - 8;
      return coord_type'((v < 0) ? 0 : (v > 63) ? 63 : v);
   endfunction

   // Driver: offers queued commands in bursts separated by random gaps.
   int          burst_left = 1;
   int          gap_left   = 0;
   command_type drv_cmd;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            rasterise(req_tuser, req_tdata[REQ_X_LO +: COORD_W], req_tdata[REQ_Y_LO +: COORD_W]);
         if (req_tvalid && !req_tready)
            input_stalls++;
         else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            drv_cmd = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= drv_cmd.op;
            req_tdata  <= {{(REQ_DATA_W - 2 * COORD_W){1'b0}}, drv_cmd.y, drv_cmd.x};
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: changes its readiness profile every so often, and once holds off
   // for a long stretch so that the block backs up into its input.
   int  rx_count  = 0;
   int  hold_left = 0;
   int  mode_left = 0;
   int  ready_pct = 100;
   bit  held_once = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rx_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held_once && rx_count >= 60) begin
            held_once = 1'b1;
            hold_left = HOLD_OFF;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(20, 80);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 80;
                  2: ready_pct = 50;
                  default: ready_pct = 20;
               endcase
            end else begin
               mode_left--;
            end
            rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   // Monitor: every accepted result is checked against the oldest expected pixel.
   raster_pixel_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_checked++;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result transaction", rsp_tdata[15:0], '0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[RSP_MAIN_X_LO +: COORD_W] !== want.main_x)
               report_mismatch("main_x", 16'(rsp_tdata[RSP_MAIN_X_LO +: COORD_W]),
                               16'(want.main_x));
            if (rsp_tdata[RSP_MAIN_Y_LO +: COORD_W] !== want.main_y)
               report_mismatch("main_y", 16'(rsp_tdata[RSP_MAIN_Y_LO +: COORD_W]),
                               16'(want.main_y));
            if (rsp_tdata[RSP_MAIN_LEVEL_LO +: LEVEL_W] !== want.main_level)
               report_mismatch("main_level", 16'(rsp_tdata[RSP_MAIN_LEVEL_LO +: LEVEL_W]),
                               16'(want.main_level));
            if (rsp_tdata[RSP_SIDE_X_LO +: SIDE_W] !== want.side_x)
               report_mismatch("side_x", 16'(rsp_tdata[RSP_SIDE_X_LO +: SIDE_W]),
                               16'(want.side_x));
            if (rsp_tdata[RSP_SIDE_Y_LO +: SIDE_W] !== want.side_y)
               report_mismatch("side_y", 16'(rsp_tdata[RSP_SIDE_Y_LO +: SIDE_W]),
                               16'(want.side_y));
            if (rsp_tdata[RSP_SIDE_LEVEL_LO +: LEVEL_W] !== want.side_level)
               report_mismatch("side_level", 16'(rsp_tdata[RSP_SIDE_LEVEL_LO +: LEVEL_W]),
                               16'(want.side_level));
            if (rsp_tuser !== want.is_empty)
               report_mismatch("empty flag", 16'(rsp_tuser), 16'(want.is_empty));
            if (rsp_tlast !== want.is_last)
               report_mismatch("last flag", 16'(rsp_tlast), 16'(want.is_last));
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sel;

      // Directed part: zero-length line straight out of reset, the tile corners,
      // both diagonals, horizontal and vertical lines walked backwards, steep
      // lines in both minor directions, exact half slope and truncated slopes.
      add_cmd(OP_LINE, 6'd0, 6'd0);
      add_cmd(OP_LINE, 6'd63, 6'd63);
      add_cmd(OP_LINE, 6'd0, 6'd63);
      add_cmd(OP_LINE, 6'd0, 6'd0);
      add_cmd(OP_MOVE, 6'd63, 6'd0);
      add_cmd(OP_LINE, 6'd0, 6'd63);
      add_cmd(OP_MOVE, 6'd10, 6'd5);
      add_cmd(OP_LINE, 6'd12, 6'd60);
      add_cmd(OP_LINE, 6'd20, 6'd3);
      add_cmd(OP_MOVE, 6'd5, 6'd5);
      add_cmd(OP_LINE, 6'd6, 6'd6);
      add_cmd(OP_LINE, 6'd6, 6'd6);
      add_cmd(OP_MOVE, 6'd0, 6'd0);
      add_cmd(OP_LINE, 6'd63, 6'd1);
      add_cmd(OP_LINE, 6'd0, 6'd2);
      add_cmd(OP_MOVE, 6'd3, 6'd40);
      add_cmd(OP_LINE, 6'd5, 6'd41);
      add_cmd(OP_LINE, 6'd2, 6'd40);
      add_cmd(OP_MOVE, 6'd63, 6'd63);
      add_cmd(OP_LINE, 6'd62, 6'd0);
      add_cmd(OP_MOVE, 6'd0, 6'd0);
      add_cmd(OP_LINE, 6'd3, 6'd1);
      add_cmd(OP_LINE, 6'd4, 6'd8);

      // Random part: mostly short lines from the current pen, some long ones,
      // some moves and some lines back onto the pen itself.
      repeat (200) begin
         sel = $urandom_range(0, 99);
         if (sel < 15)
            add_cmd(OP_MOVE, coord_type'($urandom_range(0, 63)), coord_type'($urandom_range(0, 63)));
         else if (sel < 21)
            add_cmd(OP_LINE, gen_x, gen_y);
         else if (sel < 40)
            add_cmd(OP_LINE, coord_type'($urandom_range(0, 63)), coord_type'($urandom_range(0, 63)));
         else
            add_cmd(OP_LINE, near_coord(gen_x), near_coord(gen_y));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_pixels.size() != 0);
      repeat (100) @(posedge clock);

      $display("Covered %0d pen moves and %0d lines: %0d steep, %0d shallow, %0d zero-length.",
               moves_seen, steep_lines + shallow_lines + zero_lines, steep_lines,
               shallow_lines, zero_lines);
      $display("Checked %0d pixel transactions; the input was held back for %0d cycles.",
               pixels_checked, input_stalls);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
